>>> sv/cvbe_pkg.sv
// ----------------------------------------------------------------------------
// cvbe_pkg
// Shared constants, op codes and queue status type for the variant block
// extractor.
// ----------------------------------------------------------------------------
package cvbe_pkg;

	localparam int POS_BITS_DEF    = 20;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int FIELD_POS_BITS = 20;
	localparam int RUN_BITS       = 20;
	localparam int OP_BITS        = 4;
	localparam int BASE_BITS      = 8;

	typedef enum logic [OP_BITS-1:0] {
		OP_ALN_MATCH = 4'd0,
		OP_REF_RUN   = 4'd1,
		OP_ALT_RUN   = 4'd2,
		OP_SEQ_MATCH = 4'd7,
		OP_SEQ_DIFF  = 4'd8
	} cigar_op_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

>>> sv/cvbe_col_if.sv
// ----------------------------------------------------------------------------
// cvbe_col_if
// Aligned column channel: valid/ready handshake with one column item.
// ----------------------------------------------------------------------------
interface cvbe_col_if;
	import cvbe_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      first_column;
	logic                      last_column;
	logic [OP_BITS-1:0]        op;
	logic [RUN_BITS-1:0]       run_length;
	logic [BASE_BITS-1:0]      ref_base;
	logic [BASE_BITS-1:0]      alt_base;
	logic [FIELD_POS_BITS-1:0] ref_origin;
	logic [FIELD_POS_BITS-1:0] alt_origin;

	modport source (
		output valid, first_column, last_column, op, run_length,
		       ref_base, alt_base, ref_origin, alt_origin,
		input  ready
	);

	modport sink (
		input  valid, first_column, last_column, op, run_length,
		       ref_base, alt_base, ref_origin, alt_origin,
		output ready
	);

endinterface

>>> sv/cvbe_var_if.sv
// ----------------------------------------------------------------------------
// cvbe_var_if
// Variant block channel: valid/ready handshake with one variant item.
// ----------------------------------------------------------------------------
interface cvbe_var_if #(
	parameter int POS_BITS = cvbe_pkg::POS_BITS_DEF
);
	logic                valid;
	logic                ready;
	logic [POS_BITS-1:0] var_ref_start;
	logic [POS_BITS-1:0] var_ref_len;
	logic [POS_BITS-1:0] var_alt_start;
	logic [POS_BITS-1:0] var_alt_len;
	logic                run_last;

	modport source (
		output valid, var_ref_start, var_ref_len, var_alt_start, var_alt_len, run_last,
		input  ready
	);

	modport sink (
		input  valid, var_ref_start, var_ref_len, var_alt_start, var_alt_len, run_last,
		output ready
	);

endinterface

>>> sv/cvbe_front.sv
// ----------------------------------------------------------------------------
// cvbe_front
// Accepts column items, tracks positions and the open block, and queues the
// blocks each item flushes.
// ----------------------------------------------------------------------------
module cvbe_front #(
	parameter int POS_BITS = cvbe_pkg::POS_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	cvbe_col_if.sink                column,
	input  cvbe_pkg::q_stat_t       q_stat,
	output logic                    push,
	output logic [8*POS_BITS+1:0]   push_entry
);
	import cvbe_pkg::*;

	localparam logic [POS_BITS-1:0] POS_MASK = {POS_BITS{1'b1}};
	localparam logic [POS_BITS-1:0] POS_ONE  = POS_BITS'(1);

	typedef struct packed {
		logic [POS_BITS-1:0] ref_start;
		logic [POS_BITS-1:0] ref_len;
		logic [POS_BITS-1:0] alt_start;
		logic [POS_BITS-1:0] alt_len;
	} blk_t;

	typedef struct packed {
		logic v0;
		blk_t b0;
		logic v1;
		blk_t b1;
	} entry_t;

	logic [POS_BITS-1:0] ref_pos_q, alt_pos_q;
	logic                open_q;
	blk_t                blk_q;

	logic [POS_BITS-1:0] cur_ref, cur_alt, nxt_ref, nxt_alt;
	logic [POS_BITS-1:0] org_ref, org_alt, run_sat, run_wrap;
	logic                cur_open, open_n, accept;
	blk_t                blk_n;
	entry_t              ent;

	assign column.ready = !q_stat.full;
	assign accept       = column.valid && column.ready;
	assign push         = accept && (ent.v0 || ent.v1);
	assign push_entry   = ent;

	assign org_ref  = POS_BITS'(column.ref_origin);
	assign org_alt  = POS_BITS'(column.alt_origin);
	assign run_wrap = POS_BITS'(column.run_length);
	assign run_sat  = (33'(column.run_length) > 33'(POS_MASK)) ? POS_MASK : run_wrap;

	always_comb begin
		cur_ref  = column.first_column ? org_ref : ref_pos_q;
		cur_alt  = column.first_column ? org_alt : alt_pos_q;
		cur_open = column.first_column ? 1'b0 : open_q;
		nxt_ref  = cur_ref;
		nxt_alt  = cur_alt;
		blk_n    = blk_q;
		open_n   = cur_open;
		ent      = '0;
		ent.b0   = blk_q;
		unique case (column.op) inside
			OP_ALN_MATCH, OP_SEQ_MATCH, OP_SEQ_DIFF: begin
				if (column.ref_base != column.alt_base) begin
					if (!cur_open) begin
						blk_n.ref_start = cur_ref;
						blk_n.alt_start = cur_alt;
						blk_n.ref_len   = POS_ONE;
						blk_n.alt_len   = POS_ONE;
					end else begin
						blk_n.ref_len = (blk_q.ref_len == POS_MASK) ? POS_MASK
						              : blk_q.ref_len + POS_ONE;
						blk_n.alt_len = (blk_q.alt_len == POS_MASK) ? POS_MASK
						              : blk_q.alt_len + POS_ONE;
					end
					open_n = 1'b1;
				end else begin
					ent.v0 = cur_open;
					open_n = 1'b0;
				end
				nxt_ref = cur_ref + POS_ONE;
				nxt_alt = cur_alt + POS_ONE;
			end
			OP_REF_RUN: begin
				ent.v0          = cur_open;
				blk_n.ref_start = cur_ref;
				blk_n.alt_start = cur_alt;
				blk_n.ref_len   = run_sat;
				blk_n.alt_len   = '0;
				open_n          = 1'b1;
				nxt_ref         = cur_ref + run_wrap;
			end
			OP_ALT_RUN: begin
				ent.v0          = cur_open;
				blk_n.ref_start = cur_ref;
				blk_n.alt_start = cur_alt;
				blk_n.ref_len   = '0;
				blk_n.alt_len   = run_sat;
				open_n          = 1'b1;
				nxt_alt         = cur_alt + run_wrap;
			end
			default: begin
			end
		endcase
		ent.b1 = blk_n;
		ent.v1 = column.last_column && open_n;
		if (column.last_column) begin
			open_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_pos_q <= '0;
			alt_pos_q <= '0;
			open_q    <= 1'b0;
			blk_q     <= '0;
		end else if (accept) begin
			ref_pos_q <= nxt_ref;
			alt_pos_q <= nxt_alt;
			open_q    <= open_n;
			blk_q     <= blk_n;
		end
	end

endmodule

>>> sv/cvbe_queue.sv
// ----------------------------------------------------------------------------
// cvbe_queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module cvbe_queue #(
	parameter int WIDTH = 2 + 8 * cvbe_pkg::POS_BITS_DEF,
	parameter int DEPTH = cvbe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [WIDTH-1:0]     push_entry,
	input  logic                 pop,
	output logic [WIDTH-1:0]     head_entry,
	output cvbe_pkg::q_stat_t    q_stat
);
	import cvbe_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign q_stat.full  = (count_q == CNT_FULL);
	assign q_stat.empty = (count_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head_entry   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> sv/cvbe_back.sv
// ----------------------------------------------------------------------------
// cvbe_back
// Unpacks queued entries into one variant item per cycle while the receiver
// is ready and the queue is not empty, through an output register.
// ----------------------------------------------------------------------------
module cvbe_back #(
	parameter int POS_BITS = cvbe_pkg::POS_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cvbe_pkg::q_stat_t       q_stat,
	input  logic [8*POS_BITS+1:0]   head_entry,
	output logic                    pop,
	cvbe_var_if.source              variant
);
	import cvbe_pkg::*;

	typedef struct packed {
		logic [POS_BITS-1:0] ref_start;
		logic [POS_BITS-1:0] ref_len;
		logic [POS_BITS-1:0] alt_start;
		logic [POS_BITS-1:0] alt_len;
	} blk_t;

	typedef struct packed {
		logic v0;
		blk_t b0;
		logic v1;
		blk_t b1;
	} entry_t;

	entry_t head;
	blk_t   sel_blk;
	logic   phase_q, sel_first, entry_done, load;
	logic   valid_q, run_last_q;
	blk_t   blk_q;

	assign head       = head_entry;
	assign sel_first  = !phase_q && head.v0;
	assign entry_done = !(sel_first && head.v1);
	assign sel_blk    = sel_first ? head.b0 : head.b1;
	assign load       = !q_stat.empty && (!valid_q || variant.ready);
	assign pop        = load && entry_done;

	assign variant.valid         = valid_q;
	assign variant.var_ref_start = blk_q.ref_start;
	assign variant.var_ref_len   = blk_q.ref_len;
	assign variant.var_alt_start = blk_q.alt_start;
	assign variant.var_alt_len   = blk_q.alt_len;
	assign variant.run_last      = run_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				phase_q <= !entry_done;
			end else if (variant.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			blk_q      <= sel_blk;
			run_last_q <= entry_done;
		end
	end

endmodule

>>> sv/cigar_variant_block_extractor.sv
// ----------------------------------------------------------------------------
// cigar_variant_block_extractor
// Turns a stream of aligned columns and indel runs into variant blocks.
// ----------------------------------------------------------------------------
// Channels: column (sink) takes one aligned column or indel run per item;
// variant (source) gives one variant block per item, with run_last set on
// the final block caused by a column item. A column item causes zero, one
// or two variant items.
// Throughput: one column item per cycle while the queue is not full;
// variant items leave at one per cycle while the receiver is ready, set
// by the single output register of the back part.
// A column item is written to the queue at the edge that takes it; its
// variant item then passes from the queue into the output register and on
// to the variant channel; a second block from the same column follows it.
// A queue of QUEUE_DEPTH entries sits between the front and back parts;
// column.ready drops only while that queue is full.
// Reset clears positions, the open block, the queue and the output valid
// flag; no variant item is valid after reset.
// When the variant receiver stalls, the output item holds, the queue
// fills, and then the column channel stalls; nothing is dropped.
// ----------------------------------------------------------------------------
module cigar_variant_block_extractor #(
	parameter int POS_BITS    = cvbe_pkg::POS_BITS_DEF,
	parameter int QUEUE_DEPTH = cvbe_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	cvbe_col_if.sink   column,
	cvbe_var_if.source variant
);
	import cvbe_pkg::*;

	localparam int ENTRY_BITS = 2 + 8 * POS_BITS;

	logic                  push, pop;
	logic [ENTRY_BITS-1:0] push_entry, head_entry;
	q_stat_t               q_stat;

	cvbe_front #(
		.POS_BITS (POS_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.column     (column),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	cvbe_queue #(
		.WIDTH (ENTRY_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_entry (head_entry),
		.q_stat     (q_stat)
	);

	cvbe_back #(
		.POS_BITS (POS_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_stat     (q_stat),
		.head_entry (head_entry),
		.pop        (pop),
		.variant    (variant)
	);

endmodule
